/* rtl/ckbm_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// ckbm_pkg
// Shared types and constants of the color key box measurement unit.
// ---------------------------------------------------------------------------
package ckbm_pkg;

	localparam int MAX_DIM_DEF = 4096;

	localparam int PIXEL_W    = 32;
	localparam int BOX_W      = 20;
	localparam int RESULT_W   = 1 + 4 * BOX_W;
	localparam int RESULT_PAD = ((RESULT_W + 7) / 8) * 8;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int DIM_CFG_W  = 13;
	localparam int SHIFT_W    = 5;
	localparam int LOSS_W     = 3;
	localparam int SCALE_W    = 8;
	localparam int LEVEL_W    = 8;

	localparam logic [LEVEL_W-1:0] KEY_LEVEL = 8'hFF;

	localparam int                    WIDTH_RST  = 640;
	localparam int                    HEIGHT_RST = 480;
	localparam logic [PIXEL_W-1:0]    MASK_RST   = 32'h0000_FF00;
	localparam logic [SHIFT_W-1:0]    SHIFT_RST  = 5'd8;
	localparam logic [LOSS_W-1:0]     LOSS_RST   = 3'd0;
	localparam logic [SCALE_W-1:0]    SCALE_RST  = 8'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 3'd0,
		REG_IMAGE_HEIGHT = 3'd1,
		REG_GREEN_MASK   = 3'd2,
		REG_GREEN_SHIFT  = 3'd3,
		REG_GREEN_LOSS   = 3'd4,
		REG_SCALE_X      = 3'd5,
		REG_SCALE_Y      = 3'd6
	} cfg_reg_t;

endpackage : ckbm_pkg
`default_nettype wire

/* rtl/color_key_box_measure_unit.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// color_key_box_measure_unit
// Finds the key-green box in a raster-ordered frame and reports it per frame.
// ---------------------------------------------------------------------------
// The unit takes one pixel word per cycle when not held off as described below,
// and returns one result word on the last pixel of each frame; that pixel passes
// through the input register and then the result register. A finished result
// waiting at the output holds back only the last pixel of the next frame.
// In the cycle after each configuration write the input is held off while the
// frame size product is recomputed into its register.
module color_key_box_measure_unit #(
	parameter int MAX_DIM = ckbm_pkg::MAX_DIM_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [ckbm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [ckbm_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	input  wire logic                                  s_axis_tvalid,
	output      logic                                  s_axis_tready,
	// [31:0] pixel_word
	input  wire logic [ckbm_pkg::PIXEL_W-1:0]          s_axis_tdata,
	output      logic                                  m_axis_tvalid,
	input  wire logic                                  m_axis_tready,
	// [0] box_found, [20:1] box_left, [40:21] box_top,
	// [60:41] box_extent_x, [80:61] box_extent_y, zero above
	output      logic [ckbm_pkg::RESULT_PAD-1:0]       m_axis_tdata
);
	import ckbm_pkg::*;

	localparam int POS_W = $clog2(MAX_DIM);
	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int IDX_W = 2 * POS_W;
	localparam int PRB_W = IDX_W + 1;
	localparam int HGT_W = IDX_W + 1;
	localparam int W_RST = (WIDTH_RST > MAX_DIM) ? MAX_DIM : WIDTH_RST;
	localparam int H_RST = (HEIGHT_RST > MAX_DIM) ? MAX_DIM : HEIGHT_RST;
	localparam int LAST_RST = W_RST * H_RST - 1;

	typedef enum logic [1:0] {
		PH_SEARCH,
		PH_WIDTH,
		PH_HEIGHT,
		PH_DONE
	} phase_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_CFG_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (32'(v) > MAX_DIM) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = DIM_W'(v);
		end
		return r;
	endfunction

	function automatic logic [BOX_W-1:0] scale_box(input logic [BOX_W-1:0] a,
		input logic [SCALE_W-1:0] s);
		logic [BOX_W-1:0] p;
		p = a * BOX_W'(s);
		return p;
	endfunction

	// Configuration registers.
	logic [DIM_W-1:0]   width_q;
	logic [DIM_W-1:0]   height_q;
	logic [PIXEL_W-1:0] mask_q;
	logic [SHIFT_W-1:0] shift_q;
	logic [LOSS_W-1:0]  loss_q;
	logic [SCALE_W-1:0] scale_x_q;
	logic [SCALE_W-1:0] scale_y_q;
	logic [IDX_W-1:0]   last_q;
	logic               pend_q;
	logic [2*DIM_W-1:0] area;

	assign area = (2 * DIM_W)'(width_q) * (2 * DIM_W)'(height_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= DIM_W'(W_RST);
			height_q  <= DIM_W'(H_RST);
			mask_q    <= MASK_RST;
			shift_q   <= SHIFT_RST;
			loss_q    <= LOSS_RST;
			scale_x_q <= SCALE_RST;
			scale_y_q <= SCALE_RST;
			last_q    <= IDX_W'(LAST_RST);
			pend_q    <= 1'b0;
		end else begin
			pend_q <= cfg_we;
			last_q <= IDX_W'(area - (2 * DIM_W)'(1));
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_IMAGE_WIDTH:  width_q   <= clamp_dim(cfg_wdata[DIM_CFG_W-1:0]);
					REG_IMAGE_HEIGHT: height_q  <= clamp_dim(cfg_wdata[DIM_CFG_W-1:0]);
					REG_GREEN_MASK:   mask_q    <= cfg_wdata[PIXEL_W-1:0];
					REG_GREEN_SHIFT:  shift_q   <= cfg_wdata[SHIFT_W-1:0];
					REG_GREEN_LOSS:   loss_q    <= cfg_wdata[LOSS_W-1:0];
					REG_SCALE_X:      scale_x_q <= cfg_wdata[SCALE_W-1:0];
					REG_SCALE_Y:      scale_y_q <= cfg_wdata[SCALE_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	// Input register and scan state.
	logic               valid_s1;
	logic [PIXEL_W-1:0] pixel_s1;
	phase_t             phase_q;
	logic [POS_W-1:0]   col_q;
	logic [IDX_W-1:0]   row_q;
	logic [IDX_W-1:0]   idx_q;
	logic [PRB_W-1:0]   probe_q;
	logic [POS_W-1:0]   first_col_q;
	logic [IDX_W-1:0]   first_row_q;
	logic [DIM_W-1:0]   run_q;
	logic [HGT_W-1:0]   hgt_q;
	logic               out_valid_q;

	phase_t             phase_n;
	logic [PRB_W-1:0]   probe_n;
	logic [POS_W-1:0]   first_col_n;
	logic [IDX_W-1:0]   first_row_n;
	logic [DIM_W-1:0]   run_n;
	logic [HGT_W-1:0]   hgt_n;
	logic [PIXEL_W-1:0] shifted;
	logic               green;
	logic               is_last;
	logic               out_free;
	logic               advance;
	logic               accept;
	logic [DIM_W-1:0]   col_inc;

	assign shifted  = (pixel_s1 & mask_q) >> shift_q;
	assign green    = LEVEL_W'(shifted << loss_q) == KEY_LEVEL;
	assign is_last  = idx_q >= last_q;
	assign out_free = !out_valid_q || m_axis_tready;
	assign advance  = valid_s1 && !pend_q && (!is_last || out_free);
	assign s_axis_tready = !pend_q && (!valid_s1 || advance);
	assign accept   = s_axis_tvalid && s_axis_tready;
	assign col_inc  = DIM_W'(col_q) + DIM_W'(1);

	always_comb begin
		phase_n     = phase_q;
		probe_n     = probe_q;
		first_col_n = first_col_q;
		first_row_n = first_row_q;
		run_n       = run_q;
		hgt_n       = hgt_q;
		unique case (phase_q)
			PH_SEARCH: begin
				if (green) begin
					first_col_n = col_q;
					first_row_n = row_q;
					run_n       = DIM_W'(1);
					if (DIM_W'(1) >= width_q) begin
						hgt_n   = HGT_W'(1);
						probe_n = PRB_W'(idx_q) + PRB_W'(width_q);
						phase_n = PH_HEIGHT;
					end else begin
						phase_n = PH_WIDTH;
					end
				end
			end
			PH_WIDTH: begin
				if (green) begin
					run_n = run_q + DIM_W'(1);
					if (run_n >= width_q) begin
						hgt_n   = HGT_W'(1);
						probe_n = PRB_W'(idx_q) + PRB_W'(width_q);
						phase_n = PH_HEIGHT;
					end
				end else begin
					hgt_n   = HGT_W'(1);
					probe_n = PRB_W'(idx_q) + PRB_W'(width_q) - PRB_W'(1);
					phase_n = PH_HEIGHT;
				end
			end
			PH_HEIGHT: begin
				if (PRB_W'(idx_q) == probe_q) begin
					if (green) begin
						hgt_n   = hgt_q + HGT_W'(1);
						probe_n = PRB_W'(idx_q) + PRB_W'(width_q);
					end else begin
						phase_n = PH_DONE;
					end
				end
			end
			PH_DONE: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			phase_q     <= PH_SEARCH;
			col_q       <= '0;
			row_q       <= '0;
			idx_q       <= '0;
			probe_q     <= '0;
			first_col_q <= '0;
			first_row_q <= '0;
			run_q       <= '0;
			hgt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance && is_last) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (advance) begin
				if (is_last) begin
					phase_q     <= PH_SEARCH;
					col_q       <= '0;
					row_q       <= '0;
					idx_q       <= '0;
					probe_q     <= '0;
					first_col_q <= '0;
					first_row_q <= '0;
					run_q       <= '0;
					hgt_q       <= '0;
				end else begin
					phase_q     <= phase_n;
					probe_q     <= probe_n;
					first_col_q <= first_col_n;
					first_row_q <= first_row_n;
					run_q       <= run_n;
					hgt_q       <= hgt_n;
					idx_q       <= idx_q + IDX_W'(1);
					if (col_inc >= width_q) begin
						col_q <= '0;
						row_q <= row_q + IDX_W'(1);
					end else begin
						col_q <= col_q + POS_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1 <= s_axis_tdata;
		end
	end

	// Result register.
	logic [BOX_W-1:0] left_q;
	logic [BOX_W-1:0] top_q;
	logic [BOX_W-1:0] ext_x_q;
	logic [BOX_W-1:0] ext_y_q;
	logic             found_q;

	always_ff @(posedge clk) begin
		if (advance && is_last) begin
			found_q <= phase_n != PH_SEARCH;
			left_q  <= scale_box(BOX_W'(first_col_n), scale_x_q);
			top_q   <= scale_box(BOX_W'(first_row_n), scale_y_q);
			ext_x_q <= scale_box(BOX_W'(run_n), scale_x_q);
			ext_y_q <= scale_box(BOX_W'(hgt_n), scale_y_q);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = RESULT_PAD'({ext_y_q, ext_x_q, top_q, left_q, found_q});

	// A frame end returns the scan to its starting point.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && is_last |=> idx_q == '0 && phase_q == PH_SEARCH && col_q == '0)
		else $error("scan state not cleared after frame end");

	// Nothing is taken in right after a configuration write.
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !s_axis_tready)
		else $error("input accepted while frame size is recomputed");

	// A frame without a key pixel reports an empty box.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !found_q |-> left_q == '0 && top_q == '0 && ext_x_q == '0
			&& ext_y_q == '0)
		else $error("empty frame reports a nonzero box");

	// Height measurement always starts from one counted row.
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HEIGHT || phase_q == PH_DONE |-> hgt_q != '0)
		else $error("height phase without a counted row");

endmodule : color_key_box_measure_unit
`default_nettype wire

/* test/color_key_box_measure_unit_test.sv */
// ---------------------------------------------------------------------------
// color_key_box_measure_unit_test
// Self-checking testbench for the color key box measurement unit.
// ---------------------------------------------------------------------------
// Pixel words are streamed in raster order. A predictor of the scan follows
// every accepted word and queues the box expected at each frame end. Words on
// the result stream are compared field by field with that queue. A short
// table of hand-made frames runs first. Random phases follow, each with its
// own settings and idle pattern. Then come a long run and a long column at
// the largest dimensions, each cut short by a smaller frame size, and a long
// output stall that backs up the input.
// ---------------------------------------------------------------------------
module color_key_box_measure_unit_test;
	import ckbm_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASE_COUNT = 16;
	localparam int PHASE_WORDS = 70;

	typedef enum logic [1:0] {ST_SEEK, ST_RUN, ST_DROP, ST_DONE} scan_state_t;
	typedef enum logic [2:0] {PAT_BOX, PAT_FULL, PAT_TAIL, PAT_NOISE, PAT_BLANK} pattern_t;

	typedef struct packed {
		logic [BOX_W-1:0] ext_y;
		logic [BOX_W-1:0] ext_x;
		logic [BOX_W-1:0] top;
		logic [BOX_W-1:0] left;
		logic             found;
	} box_t;

	typedef struct packed {
		logic [DIM_CFG_W-1:0] width;
		logic [DIM_CFG_W-1:0] height;
		logic [PIXEL_W-1:0]   mask;
		logic [SHIFT_W-1:0]   shift;
		logic [LOSS_W-1:0]    loss;
		logic [SCALE_W-1:0]   scale_x;
		logic [SCALE_W-1:0]   scale_y;
	} setup_t;

	typedef struct packed {
		logic [PIXEL_W-1:0] pixel;
		logic               typed;
		box_t               want;
	} probe_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [PIXEL_W-1:0]    s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [RESULT_PAD-1:0] m_axis_tdata;

	// Frames of three by two pixels with the reset key settings.
	probe_row_t probe_table [24] = '{
		{32'h0000_0000, 1'b0, 81'd0},
		{32'h0000_FE00, 1'b0, 81'd0},
		{32'h00FF_00FF, 1'b0, 81'd0},
		{32'hFFFF_00FF, 1'b0, 81'd0},
		{32'h0000_7F00, 1'b0, 81'd0},
		{32'hFF00_00FF, 1'b1, {20'd0, 20'd0, 20'd0, 20'd0, 1'b0}},
		{32'h0000_0000, 1'b0, 81'd0},
		{32'h0000_FF00, 1'b0, 81'd0},
		{32'hFFFF_FFFF, 1'b0, 81'd0},
		{32'h00FF_0000, 1'b0, 81'd0},
		{32'h0000_FF00, 1'b0, 81'd0},
		{32'h1234_FF56, 1'b0, 81'd0},
		{32'hFFFF_FFFF, 1'b0, 81'd0},
		{32'h0000_FF00, 1'b0, 81'd0},
		{32'hABCD_FFEF, 1'b0, 81'd0},
		{32'h0000_FF00, 1'b0, 81'd0},
		{32'h8000_FF01, 1'b0, 81'd0},
		{32'h7F7F_FF7F, 1'b1, {20'd2, 20'd3, 20'd0, 20'd0, 1'b1}},
		{32'h0000_0000, 1'b0, 81'd0},
		{32'hFFFF_00FF, 1'b0, 81'd0},
		{32'h0000_FE00, 1'b0, 81'd0},
		{32'h0000_01FF, 1'b0, 81'd0},
		{32'hFFFF_7FFF, 1'b0, 81'd0},
		{32'h0000_FF00, 1'b1, {20'd0, 20'd1, 20'd1, 20'd2, 1'b1}}
	};

	setup_t      cfg_now;
	scan_state_t scan_state;
	int unsigned scan_col, scan_row, scan_index, probe_at;
	int unsigned key_col, key_row, run_len, col_height;
	box_t        boxes_due [$];
	bit          frame_done;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_asked = 0;
	int hold_granted = 0;
	int hold_cycles = 0;
	int mismatch_count = 0;
	int cycle_count = 0;
	box_t seen_box, owed_box;

	color_key_box_measure_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #6 clk = ~clk;

	function automatic int unsigned dim_used(input logic [DIM_CFG_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_DIM_DEF)
			return MAX_DIM_DEF;
		return v;
	endfunction

	function automatic void clear_scan();
		scan_state = ST_SEEK;
		scan_col = 0;
		scan_row = 0;
		scan_index = 0;
		probe_at = 0;
		key_col = 0;
		key_row = 0;
		run_len = 0;
		col_height = 0;
	endfunction

	// Follows the scan for one accepted pixel word; returns 1 at a frame end.
	function automatic bit measure_pixel(input logic [PIXEL_W-1:0] px, output box_t box);
		int unsigned w, h, idx;
		longint unsigned last;
		logic [PIXEL_W-1:0] picked;
		logic [LEVEL_W-1:0] level;
		bit key;
		w = dim_used(cfg_now.width);
		h = dim_used(cfg_now.height);
		last = longint'(w) * h - 1;
		picked = (px & cfg_now.mask) >> cfg_now.shift;
		level = LEVEL_W'(picked << cfg_now.loss);
		key = (level == KEY_LEVEL);
		idx = scan_index;
		box = '0;
		case (scan_state)
			ST_SEEK: if (key) begin
				key_col = scan_col;
				key_row = scan_row;
				run_len = 1;
				if (run_len >= w) begin
					col_height = 1;
					probe_at = idx + w;
					scan_state = ST_DROP;
				end else
					scan_state = ST_RUN;
			end
			ST_RUN: if (key) begin
				run_len++;
				if (run_len >= w) begin
					col_height = 1;
					probe_at = idx + w;
					scan_state = ST_DROP;
				end
			end else begin
				col_height = 1;
				probe_at = idx + w - 1;
				scan_state = ST_DROP;
			end
			ST_DROP: if (idx == probe_at) begin
				if (key) begin
					col_height++;
					probe_at = idx + w;
				end else
					scan_state = ST_DONE;
			end
			default: ;
		endcase
		if (idx >= last) begin
			box.found = (scan_state != ST_SEEK);
			box.left = BOX_W'(key_col * cfg_now.scale_x);
			box.top = BOX_W'(key_row * cfg_now.scale_y);
			box.ext_x = BOX_W'(run_len * cfg_now.scale_x);
			box.ext_y = BOX_W'(col_height * cfg_now.scale_y);
			clear_scan();
			return 1;
		end
		scan_index = idx + 1;
		if (scan_col + 1 >= w) begin
			scan_col = 0;
			scan_row++;
		end else
			scan_col++;
		return 0;
	endfunction

	function automatic logic [PIXEL_W-1:0] make_pixel(input bit key);
		logic [PIXEL_W-1:0] px;
		px = $urandom;
		if (key)
			px = px | (32'hFF << cfg_now.shift);
		else
			px = px & ~(32'h1 << (cfg_now.shift + $urandom_range(7)));
		return px;
	endfunction

	function automatic setup_t pick_setup(input int p);
		setup_t s;
		s.width = ($urandom_range(9) == 0) ? 13'd0 : DIM_CFG_W'($urandom_range(10, 1));
		s.height = ($urandom_range(9) == 0) ? 13'd0 : DIM_CFG_W'($urandom_range(6, 1));
		s.shift = SHIFT_W'($urandom_range(24));
		s.loss = ($urandom_range(3) == 0) ? LOSS_W'($urandom_range(7, 1)) : 3'd0;
		s.mask = $urandom | (32'hFF << s.shift);
		s.scale_x = SCALE_W'($urandom);
		s.scale_y = SCALE_W'($urandom);
		case (p)
			0: begin
				s.shift = 5'd0;
				s.mask = 32'h0000_00FF;
				s.loss = 3'd0;
			end
			1: begin
				s.shift = 5'd24;
				s.mask = 32'hFF00_0000;
				s.loss = 3'd0;
			end
			2: begin
				s.shift = 5'd31;
				s.loss = 3'd7;
				s.mask = '1;
			end
			3: s.mask = 32'h0;
			4: begin
				s.mask = '1;
				s.loss = 3'd0;
				s.scale_x = 8'd0;
				s.scale_y = 8'd0;
			end
			5: begin
				s.loss = 3'd0;
				s.scale_x = 8'hFF;
				s.scale_y = 8'hFF;
			end
			default: ;
		endcase
		return s;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < 40)
			$display("MISMATCH at cycle %0d: %s", cycle_count, msg);
		mismatch_count++;
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val, input int bits);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= (bits < 32) ? (val | ($urandom << bits)) : val;
		@(posedge clk);
	endtask

	task automatic apply_config(input setup_t s);
		write_reg(REG_IMAGE_WIDTH, 32'(s.width), DIM_CFG_W);
		write_reg(REG_IMAGE_HEIGHT, 32'(s.height), DIM_CFG_W);
		write_reg(REG_GREEN_MASK, s.mask, PIXEL_W);
		write_reg(REG_GREEN_SHIFT, 32'(s.shift), SHIFT_W);
		write_reg(REG_GREEN_LOSS, 32'(s.loss), LOSS_W);
		write_reg(REG_SCALE_X, 32'(s.scale_x), SCALE_W);
		write_reg(REG_SCALE_Y, 32'(s.scale_y), SCALE_W);
		cfg_we <= 1'b0;
		cfg_now = s;
	endtask

	task automatic send_pixel(input logic [PIXEL_W-1:0] px, input bit typed, input box_t want);
		box_t box;
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= px;
		do @(posedge clk); while (!s_axis_tready);
		frame_done = measure_pixel(px, box);
		if (frame_done)
			boxes_due.insert(boxes_due.size(), typed ? want : box);
	endtask

	// Sends words until the current frame closes or cap words have gone.
	task automatic run_frame(input pattern_t pat, input int cap, output int n);
		int unsigned w, h, c0, r0, bw, bh;
		bit key;
		w = dim_used(cfg_now.width);
		h = dim_used(cfg_now.height);
		c0 = $urandom_range(w - 1);
		r0 = $urandom_range(h - 1);
		bw = $urandom_range(w, 1);
		bh = $urandom_range(h, 1);
		n = 0;
		frame_done = 0;
		while (!frame_done && n < cap) begin
			case (pat)
				PAT_BOX: key = scan_col >= c0 && scan_col < c0 + bw &&
					scan_row >= r0 && scan_row < r0 + bh;
				PAT_FULL: key = 1'b1;
				PAT_TAIL: key = (scan_index == w * h - 1);
				PAT_NOISE: key = $urandom_range(1);
				default: key = 1'b0;
			endcase
			if (pat == PAT_BOX && $urandom_range(19) == 0)
				key = !key;
			send_pixel(make_pixel(key), 1'b0, '0);
			n++;
		end
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (boxes_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_cycles != 0) begin
			m_axis_tready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else if (hold_asked != hold_granted) begin
			hold_granted <= hold_asked;
			hold_cycles <= 400;
			m_axis_tready <= 1'b0;
		end else
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen_box = box_t'(m_axis_tdata[RESULT_W-1:0]);
			if (m_axis_tdata[RESULT_PAD-1:RESULT_W] !== '0)
				report_mismatch("nonzero padding above the result fields");
			if (boxes_due.size() == 0)
				report_mismatch("result word with no frame end pending");
			else begin
				owed_box = boxes_due.pop_front();
				if (seen_box.found !== owed_box.found)
					report_mismatch($sformatf("box_found: got %0d, expected %0d",
						seen_box.found, owed_box.found));
				if (seen_box.left !== owed_box.left)
					report_mismatch($sformatf("box_left: got %0d, expected %0d",
						seen_box.left, owed_box.left));
				if (seen_box.top !== owed_box.top)
					report_mismatch($sformatf("box_top: got %0d, expected %0d",
						seen_box.top, owed_box.top));
				if (seen_box.ext_x !== owed_box.ext_x)
					report_mismatch($sformatf("box_extent_x: got %0d, expected %0d",
						seen_box.ext_x, owed_box.ext_x));
				if (seen_box.ext_y !== owed_box.ext_y)
					report_mismatch($sformatf("box_extent_y: got %0d, expected %0d",
						seen_box.ext_y, owed_box.ext_y));
			end
		end
	end

	initial begin
		setup_t s, grown;
		int p, n, phase_words, fs;
		pattern_t pat;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_IMAGE_WIDTH;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_now.width = DIM_CFG_W'(WIDTH_RST);
		cfg_now.height = DIM_CFG_W'(HEIGHT_RST);
		cfg_now.mask = MASK_RST;
		cfg_now.shift = SHIFT_RST;
		cfg_now.loss = LOSS_RST;
		cfg_now.scale_x = SCALE_RST;
		cfg_now.scale_y = SCALE_RST;
		clear_scan();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		s = cfg_now;
		s.width = 13'd3;
		s.height = 13'd2;
		apply_config(s);
		foreach (probe_table[i])
			send_pixel(probe_table[i].pixel, probe_table[i].typed, probe_table[i].want);
		settle();

		for (p = 0; p < PHASE_COUNT; p++) begin
			apply_config(pick_setup(p));
			case (p % 4)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 83; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 83; end
				default: begin send_idle_pct = 23; stall_pct = 23; end
			endcase
			phase_words = 0;
			fs = dim_used(cfg_now.width) * dim_used(cfg_now.height);
			// Settings rewritten part way through a frame.
			if (p % 5 == 3 && fs > 1) begin
				run_frame(PAT_BOX, $urandom_range(fs - 1, 1), n);
				phase_words += n;
				settle();
				grown = cfg_now;
				grown.width = DIM_CFG_W'($urandom_range(5, 1));
				grown.height = DIM_CFG_W'($urandom_range(4, 1));
				apply_config(grown);
			end
			while (phase_words < PHASE_WORDS) begin
				case ($urandom_range(9))
					0: pat = PAT_NOISE;
					1: pat = PAT_BLANK;
					2: pat = PAT_FULL;
					3: pat = PAT_TAIL;
					default: pat = PAT_BOX;
				endcase
				run_frame(pat, 1 << 30, n);
				phase_words += n;
			end
			settle();
		end

		// Largest dimensions: a long run, then a long column, each ended early
		// by shrinking the frame below the current pixel index.
		send_idle_pct = 0;
		stall_pct = 0;
		s.width = 13'h1FFF;
		s.height = 13'd0;
		s.mask = 32'h0000_FF00;
		s.shift = 5'd8;
		s.loss = 3'd0;
		s.scale_x = 8'hFF;
		s.scale_y = 8'hFF;
		apply_config(s);
		run_frame(PAT_FULL, 48, n);
		settle();
		grown = s;
		grown.width = 13'd2;
		grown.height = 13'd2;
		apply_config(grown);
		run_frame(PAT_TAIL, 1 << 30, n);
		settle();
		s.width = 13'd0;
		s.height = 13'h1FFF;
		apply_config(s);
		run_frame(PAT_FULL, 48, n);
		settle();
		apply_config(grown);
		run_frame(PAT_TAIL, 1 << 30, n);
		settle();

		// A long output stall while small frames keep coming.
		s.width = 13'd2;
		s.height = 13'd2;
		s.scale_x = 8'd3;
		s.scale_y = 8'd5;
		apply_config(s);
		hold_asked++;
		repeat (15) run_frame(PAT_BOX, 1 << 30, n);
		settle();

		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* sim.f */
rtl/ckbm_pkg.sv
rtl/color_key_box_measure_unit.sv
test/color_key_box_measure_unit_test.sv
